// File: hdl/motor_command_decoder_assert.svh
// Assertion macros used by the motor command decoder queue module.
`ifndef MOTOR_COMMAND_DECODER_ASSERT_SVH
`define MOTOR_COMMAND_DECODER_ASSERT_SVH

`define MCD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define MCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/mcd_pkg.sv
// Types and constants of the motor command decoder.
package mcd_pkg;

   typedef enum logic [1:0] {
      ACT_ECHO  = 2'd0,
      ACT_STOP  = 2'd1,
      ACT_DRIVE = 2'd2
   } action_type;

   typedef logic signed [12:0] speed_type;
   typedef logic [11:0]        speed_store_type;
   typedef logic [17:0]        ticks_type;
   typedef logic [0:0]         csr_index_type;

   typedef struct packed {
      action_type action;
      speed_type  speed_one;
      speed_type  speed_two;
      ticks_type  run_ticks;
      logic [7:0] echo_byte;
   } entry_type;

   localparam logic [7:0] CMD_SET      = 8'h06;
   localparam logic [7:0] CMD_STOP     = 8'h88;
   localparam logic [7:0] CMD_FORWARD  = 8'h99;
   localparam logic [7:0] CMD_BACKWARD = 8'h03;
   localparam logic [7:0] CMD_RIGHT    = 8'h04;
   localparam logic [7:0] CMD_LEFT     = 8'h05;

   localparam logic [7:0] SEL_FORWARD    = 8'd1;
   localparam logic [7:0] SEL_BACKWARD   = 8'd2;
   localparam logic [7:0] SEL_INNER      = 8'd3;
   localparam logic [7:0] SEL_OUTER      = 8'd4;
   localparam logic [7:0] SEL_OUTER_TIME = 8'd5;
   localparam logic [7:0] SEL_SPIN_TIME  = 8'd6;
   localparam logic [7:0] SEL_STRAIGHT   = 8'd7;

   localparam logic [1:0] LEAD_VEHICLE = 2'd0;
   localparam logic [1:0] LEFT_VEHICLE = 2'd1;

   localparam csr_index_type CSR_VEHICLE_POSITION = 1'b0;
   localparam csr_index_type CSR_PWM_PERIOD       = 1'b1;

   localparam speed_store_type SPEED_RESET         = 12'd100;
   localparam speed_type       BACKWARD_RESET      = -13'sd100;
   localparam ticks_type       TIME_STRAIGHT_RESET = 18'd100000;
   localparam ticks_type       TIME_OUTER_RESET    = 18'd100000;
   localparam ticks_type       TIME_SPIN_RESET     = 18'd20000;
   localparam logic [15:0]     PERIOD_RESET        = 16'd1000;
   localparam logic [9:0]      TIME_SCALE          = 10'd1000;

endpackage

// File: hdl/mcd_if.sv
// Handshake channel interfaces for command bytes and drive results.
interface mcd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface mcd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [15:0] compare_one;
   logic        reverse_one;
   logic [15:0] compare_two;
   logic        reverse_two;
   logic [17:0] run_ticks;
   logic [7:0]  echo_byte;

   modport source (output valid, output action, output compare_one, output reverse_one,
                   output compare_two, output reverse_two, output run_ticks,
                   output echo_byte, input ready);
   modport sink (input valid, input action, input compare_one, input reverse_one,
                 input compare_two, input reverse_two, input run_ticks,
                 input echo_byte, output ready);
endinterface

// File: hdl/mcd_front.sv
// Front end: accepts bytes, tracks set commands and stored settings, classifies drives.
module mcd_front (
   input  logic               clock,
   input  logic               reset,
   mcd_req_if.sink            req_if,
   input  logic [1:0]         vehicle_position,
   input  logic               queue_full,
   output logic               push_valid,
   output mcd_pkg::entry_type push_entry
);
   import mcd_pkg::*;

   logic            accept;
   logic [7:0]      rx;
   speed_store_type speed_value;
   ticks_type       time_value;
   speed_type       fwd, inner, outer;

   logic            in_set_ff, in_set_in;
   logic            have_sel_ff, have_sel_in;
   logic [7:0]      selector_ff, selector_in;
   speed_store_type speed_forward_ff, speed_forward_in;
   speed_type       speed_backward_ff, speed_backward_in;
   speed_store_type speed_inner_ff, speed_inner_in;
   speed_store_type speed_outer_ff, speed_outer_in;
   ticks_type       time_outer_ff, time_outer_in;
   ticks_type       time_spin_ff, time_spin_in;
   ticks_type       time_straight_ff, time_straight_in;

   assign rx            = req_if.rx_byte;
   assign req_if.ready  = !queue_full;
   assign accept        = req_if.valid && !queue_full;
   assign speed_value   = {1'b0, rx, 3'b000} + {3'b000, rx, 1'b0};
   assign time_value    = {10'd0, rx} * {8'd0, TIME_SCALE};
   assign fwd           = $signed({1'b0, speed_forward_ff});
   assign inner         = $signed({1'b0, speed_inner_ff});
   assign outer         = $signed({1'b0, speed_outer_ff});

   always_comb begin
      in_set_in         = in_set_ff;
      have_sel_in       = have_sel_ff;
      selector_in       = selector_ff;
      speed_forward_in  = speed_forward_ff;
      speed_backward_in = speed_backward_ff;
      speed_inner_in    = speed_inner_ff;
      speed_outer_in    = speed_outer_ff;
      time_outer_in     = time_outer_ff;
      time_spin_in      = time_spin_ff;
      time_straight_in  = time_straight_ff;
      if (accept) begin
         if (in_set_ff) begin
            if (!have_sel_ff) begin
               selector_in = rx;
               have_sel_in = 1'b1;
            end else begin
               unique case (selector_ff)
                  SEL_FORWARD:    speed_forward_in  = speed_value;
                  SEL_BACKWARD:   speed_backward_in = -$signed({1'b0, speed_value});
                  SEL_INNER:      speed_inner_in    = speed_value;
                  SEL_OUTER:      speed_outer_in    = speed_value;
                  SEL_OUTER_TIME: time_outer_in     = time_value;
                  SEL_SPIN_TIME:  time_spin_in      = time_value;
                  SEL_STRAIGHT:   time_straight_in  = time_value;
                  default: begin
                  end
               endcase
               in_set_in   = 1'b0;
               have_sel_in = 1'b0;
            end
         end else if (rx == CMD_SET) begin
            in_set_in = 1'b1;
         end
      end
   end

   always_comb begin
      push_valid           = accept && !in_set_ff && (rx != CMD_SET);
      push_entry.action    = ACT_ECHO;
      push_entry.speed_one = '0;
      push_entry.speed_two = '0;
      push_entry.run_ticks = '0;
      push_entry.echo_byte = rx;
      unique case (rx)
         CMD_STOP: begin
            push_entry.action = ACT_STOP;
         end
         CMD_FORWARD: begin
            push_entry.action    = ACT_DRIVE;
            push_entry.speed_one = fwd;
            push_entry.speed_two = fwd;
            push_entry.run_ticks = time_straight_ff;
         end
         CMD_BACKWARD: begin
            push_entry.action    = ACT_DRIVE;
            push_entry.speed_one = speed_backward_ff;
            push_entry.speed_two = speed_backward_ff;
            push_entry.run_ticks = time_straight_ff;
         end
         CMD_RIGHT: begin
            push_entry.action = ACT_DRIVE;
            priority if (vehicle_position == LEAD_VEHICLE) begin
               push_entry.speed_one = fwd;
               push_entry.speed_two = speed_backward_ff;
               push_entry.run_ticks = time_spin_ff;
            end else if (vehicle_position == LEFT_VEHICLE) begin
               push_entry.speed_one = inner;
               push_entry.speed_two = outer;
               push_entry.run_ticks = time_outer_ff;
            end else begin
               push_entry.speed_one = -outer;
               push_entry.speed_two = -inner;
               push_entry.run_ticks = time_outer_ff;
            end
         end
         CMD_LEFT: begin
            push_entry.action = ACT_DRIVE;
            priority if (vehicle_position == LEAD_VEHICLE) begin
               push_entry.speed_one = speed_backward_ff;
               push_entry.speed_two = fwd;
               push_entry.run_ticks = time_spin_ff;
            end else if (vehicle_position == LEFT_VEHICLE) begin
               push_entry.speed_one = -inner;
               push_entry.speed_two = -outer;
               push_entry.run_ticks = time_outer_ff;
            end else begin
               push_entry.speed_one = outer;
               push_entry.speed_two = inner;
               push_entry.run_ticks = time_outer_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_set_ff         <= 1'b0;
         have_sel_ff       <= 1'b0;
         selector_ff       <= '0;
         speed_forward_ff  <= SPEED_RESET;
         speed_backward_ff <= BACKWARD_RESET;
         speed_inner_ff    <= SPEED_RESET;
         speed_outer_ff    <= SPEED_RESET;
         time_outer_ff     <= TIME_OUTER_RESET;
         time_spin_ff      <= TIME_SPIN_RESET;
         time_straight_ff  <= TIME_STRAIGHT_RESET;
      end else begin
         in_set_ff         <= in_set_in;
         have_sel_ff       <= have_sel_in;
         selector_ff       <= selector_in;
         speed_forward_ff  <= speed_forward_in;
         speed_backward_ff <= speed_backward_in;
         speed_inner_ff    <= speed_inner_in;
         speed_outer_ff    <= speed_outer_in;
         time_outer_ff     <= time_outer_in;
         time_spin_ff      <= time_spin_in;
         time_straight_ff  <= time_straight_in;
      end
   end

endmodule

// File: hdl/mcd_queue.sv
// Small queue that decouples the decode front end from the drive back end.
`include "motor_command_decoder_assert.svh"

module mcd_queue #(
   parameter int DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  mcd_pkg::entry_type push_entry,
   output logic               full,
   output logic               pop_valid,
   input  logic               pop_ready,
   output mcd_pkg::entry_type pop_entry
);
   import mcd_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop       = pop_valid && pop_ready;
   assign pop_entry = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `MCD_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH), "queue count beyond depth")
   `MCD_ASSERT_SAME(a_no_overflow, clock, reset, push_valid, !full, "push into a full queue")
   `MCD_ASSERT_NEXT(a_count_grows, clock, reset, push_valid && !pop, count_ff == $past(count_ff) + 1'b1, "queue count did not grow")
   `MCD_ASSERT_NEXT(a_count_drops, clock, reset, pop && !push_valid, count_ff == $past(count_ff) - 1'b1, "queue count did not drop")

endmodule

// File: hdl/mcd_back.sv
// Back end: turns queued drive items into compare values and holds the result register.
module mcd_back (
   input  logic               clock,
   input  logic               reset,
   input  logic [15:0]        pwm_period,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  mcd_pkg::entry_type pop_entry,
   mcd_rsp_if.source          rsp_if
);
   import mcd_pkg::*;

   function automatic logic [16:0] drive_channel(input speed_type speed,
                                                 input logic [15:0] period);
      logic signed [17:0] sum;
      sum = $signed({2'b00, period}) + $signed({{5{speed[12]}}, speed});
      if (speed > 0) begin
         return {1'b0, 3'b000, speed};
      end else if (sum[17]) begin
         return {1'b1, 16'd0};
      end else begin
         return {1'b1, sum[15:0]};
      end
   endfunction

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  action_ff;
   logic [15:0] compare_one_ff, compare_two_ff;
   logic        reverse_one_ff, reverse_two_ff;
   ticks_type   run_ticks_ff;
   logic [7:0]  echo_byte_ff;
   logic [16:0] chan_one, chan_two;
   logic        load;
   logic        is_drive;

   assign pop_ready = !rsp_valid_ff || rsp_if.ready;
   assign load      = pop_valid && pop_ready;
   assign is_drive  = (pop_entry.action == ACT_DRIVE);
   assign chan_one  = is_drive ? drive_channel(pop_entry.speed_one, pwm_period) : '0;
   assign chan_two  = is_drive ? drive_channel(pop_entry.speed_two, pwm_period) : '0;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         action_ff      <= pop_entry.action;
         compare_one_ff <= chan_one[15:0];
         reverse_one_ff <= chan_one[16];
         compare_two_ff <= chan_two[15:0];
         reverse_two_ff <= chan_two[16];
         run_ticks_ff   <= pop_entry.run_ticks;
         echo_byte_ff   <= pop_entry.echo_byte;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.action      = action_ff;
   assign rsp_if.compare_one = compare_one_ff;
   assign rsp_if.reverse_one = reverse_one_ff;
   assign rsp_if.compare_two = compare_two_ff;
   assign rsp_if.reverse_two = reverse_two_ff;
   assign rsp_if.run_ticks   = run_ticks_ff;
   assign rsp_if.echo_byte   = echo_byte_ff;

endmodule

// File: hdl/motor_command_decoder.sv
// Motor command decoder: command bytes in, two-channel PWM drive items out.
// Usage:
// Command bytes enter on req_if (valid/ready); one byte is taken at each edge with both high.
// Set-command bytes (the opener, the selector and the value) update stored speeds and run
// durations and give no item on rsp_if. Every other byte gives exactly one item: an echo,
// a stop, or a drive with compare values, direction pins and a run duration.
// The csr port writes the vehicle position and the PWM period; write only while idle.
// An item passes the queue, then the result register: the front end writes the queue at the
// accepting edge and the back end loads the result register when it is empty or being taken.
// Throughput is one byte per cycle; req_if.ready falls only when the queue is full.
// When the receiver holds rsp_if.ready low the result register keeps its item, the queue
// fills, and then req_if.ready goes low until the receiver takes the item.
// Synchronous reset clears the queue and the result register, sets the PWM period to 1000,
// the vehicle position to lead, and restores the default speeds and durations.
module motor_command_decoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   mcd_req_if.sink               req_if,
   mcd_rsp_if.source             rsp_if,
   input  logic                  csr_we,
   input  mcd_pkg::csr_index_type csr_index,
   input  logic [15:0]           csr_wdata
);
   import mcd_pkg::*;

   logic [1:0]  vehicle_position_ff;
   logic [15:0] pwm_period_ff;
   logic        queue_full;
   logic        push_valid;
   entry_type   push_entry;
   logic        pop_valid;
   logic        pop_ready;
   entry_type   pop_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         vehicle_position_ff <= LEAD_VEHICLE;
         pwm_period_ff       <= PERIOD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_VEHICLE_POSITION: vehicle_position_ff <= csr_wdata[1:0];
            CSR_PWM_PERIOD:       pwm_period_ff       <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   mcd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_if),
      .vehicle_position (vehicle_position_ff),
      .queue_full       (queue_full),
      .push_valid       (push_valid),
      .push_entry       (push_entry)
   );

   mcd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   mcd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pwm_period (pwm_period_ff),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .rsp_if     (rsp_if)
   );

endmodule
